// ===== src/tmat_pkg.sv =====
// shared types and constants for the angle tolerance match-or-append table
// no dependencies
package tmat_pkg;

  localparam int TABLE_DEPTH_DEF = 32;

  localparam int ANGLE_W = 16;
  localparam int MAX_ENT_W = 6;
  localparam int THR_W = 15;
  localparam int IDX_OUT_W = 5;
  localparam int TOTAL_OUT_W = 6;

  localparam logic [MAX_ENT_W-1:0] MAX_ENT_RST = 6'd32;
  localparam logic [THR_W-1:0] THR_RST = 15'd35;

  // configuration register indexes
  localparam logic CFG_MAX_ENTRIES = 1'b0;
  localparam logic CFG_MATCH_THR = 1'b1;

  typedef enum logic [1:0] {
    ST_MATCH  = 2'd0,
    ST_APPEND = 2'd1,
    ST_FULL   = 2'd2,
    ST_OVER   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_TAIL,
    S_APPEND,
    S_RESULT
  } ctrl_state_t;

  typedef struct packed {
    logic    start;
    logic    issue;
    logic    set_res;
    status_t res_kind;
    logic    append;
    logic    load_out;
  } tmat_cmd_t;

  typedef struct packed {
    logic over;
    logic empty;
    logic hit;
    logic last_issue;
    logic room;
    logic out_free;
  } tmat_stat_t;

endpackage

// ===== src/tmat_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module tmat_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/tmat_ctrl.sv =====
// controller state machine: sequences check, table scan, append and result beat
// depends on tmat_pkg
module tmat_ctrl
  import tmat_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  tmat_stat_t stat,
  output tmat_cmd_t  cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (stat.over) state_nxt = S_RESULT;
        else if (stat.empty) state_nxt = S_APPEND;
        else state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (stat.hit) state_nxt = S_RESULT;
        else if (stat.last_issue) state_nxt = S_TAIL;
      end
      S_TAIL: begin
        if (stat.hit) state_nxt = S_RESULT;
        else if (stat.room) state_nxt = S_APPEND;
        else state_nxt = S_RESULT;
      end
      S_APPEND: state_nxt = S_RESULT;
      S_RESULT: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd = '0;
    cmd.res_kind = ST_MATCH;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.start = in_tvalid;
      end
      S_CHECK: begin
        if (stat.over) begin
          cmd.set_res = 1'b1;
          cmd.res_kind = ST_OVER;
        end
      end
      S_SCAN: begin
        if (stat.hit) begin
          cmd.set_res = 1'b1;
          cmd.res_kind = ST_MATCH;
        end else begin
          cmd.issue = 1'b1;
        end
      end
      S_TAIL: begin
        if (stat.hit) begin
          cmd.set_res = 1'b1;
          cmd.res_kind = ST_MATCH;
        end else if (!stat.room) begin
          cmd.set_res = 1'b1;
          cmd.res_kind = ST_FULL;
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        cmd.set_res = 1'b1;
        cmd.res_kind = ST_APPEND;
      end
      S_RESULT: begin
        cmd.load_out = stat.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

// ===== src/tmat_dp.sv =====
// datapath: config registers, angle table, entry count, tolerance compare, output register
// depends on tmat_pkg and tmat_ram
module tmat_dp
  import tmat_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  input  logic                   cfg_index,
  input  logic [THR_W-1:0]       cfg_data,
  input  logic [ANGLE_W-1:0]     in_angle,
  input  tmat_cmd_t              cmd,
  output tmat_stat_t             stat,
  input  logic                   out_tready,
  output logic                   out_tvalid,
  output logic [IDX_OUT_W-1:0]   out_match_index,
  output status_t                out_status,
  output logic [TOTAL_OUT_W-1:0] out_entry_total
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int LIM_W = (CNT_W > MAX_ENT_W) ? CNT_W : MAX_ENT_W;

  logic [MAX_ENT_W-1:0]   max_entries_r;
  logic [THR_W-1:0]       match_thr_r;
  logic [CNT_W-1:0]       count_r;
  logic [ANGLE_W-1:0]     angle_r;
  logic [AW-1:0]          scan_idx_r;
  logic [AW-1:0]          cmp_idx_r;
  logic                   cmp_vld_r;
  logic [AW-1:0]          res_idx_r;
  status_t                res_status_r;
  logic                   out_valid_r;
  logic [IDX_OUT_W-1:0]   out_idx_r;
  status_t                out_status_r;
  logic [TOTAL_OUT_W-1:0] out_total_r;

  logic [ANGLE_W-1:0] rd_data;
  logic [AW-1:0]      app_addr;
  logic [LIM_W-1:0]   limit;
  logic [LIM_W-1:0]   count_ext;
  logic signed [ANGLE_W:0] diff;
  logic [ANGLE_W:0]   abs_diff;

  assign app_addr = AW'(count_r);

  tmat_ram #(
    .WIDTH (ANGLE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.append),
    .waddr (app_addr),
    .wdata (angle_r),
    .raddr (scan_idx_r),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entries_r <= MAX_ENT_RST;
      match_thr_r <= THR_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MAX_ENTRIES: max_entries_r <= cfg_data[MAX_ENT_W-1:0];
        CFG_MATCH_THR:   match_thr_r <= cfg_data;
        default:         match_thr_r <= match_thr_r;
      endcase
    end
  end

  // limit in force is the smaller of the register and the table size
  always_comb begin
    if (LIM_W'(max_entries_r) < LIM_W'(TABLE_DEPTH)) limit = LIM_W'(max_entries_r);
    else limit = LIM_W'(TABLE_DEPTH);
  end

  assign count_ext = LIM_W'(count_r);

  assign diff = $signed({rd_data[ANGLE_W-1], rd_data}) - $signed({angle_r[ANGLE_W-1], angle_r});
  assign abs_diff = diff[ANGLE_W] ? (ANGLE_W+1)'(-diff) : (ANGLE_W+1)'(diff);

  always_comb begin
    stat.over = count_ext > limit;
    stat.empty = (count_r == '0);
    stat.hit = cmp_vld_r && (abs_diff < (ANGLE_W+1)'(match_thr_r));
    stat.last_issue = (CNT_W'(scan_idx_r) + CNT_W'(1)) == count_r;
    stat.room = (count_r == '0) || (count_ext < limit);
    stat.out_free = !out_valid_r || out_tready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.issue;
      if (cmd.append) count_r <= count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      angle_r <= in_angle;
      scan_idx_r <= '0;
    end else if (cmd.issue) begin
      scan_idx_r <= scan_idx_r + AW'(1);
    end
    // compare stage tags the entry whose data comes back next cycle
    cmp_idx_r <= scan_idx_r;
    if (cmd.set_res) begin
      res_status_r <= cmd.res_kind;
      case (cmd.res_kind)
        ST_MATCH:  res_idx_r <= cmp_idx_r;
        ST_APPEND: res_idx_r <= app_addr;
        default:   res_idx_r <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_idx_r <= IDX_OUT_W'(res_idx_r);
      out_status_r <= res_status_r;
      out_total_r <= TOTAL_OUT_W'(count_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_match_index = out_idx_r;
  assign out_status = out_status_r;
  assign out_entry_total = out_total_r;

endmodule

// ===== src/tolerance_match_or_append_table_core.sv =====
// top level of the angle tolerance match-or-append table
// depends on tmat_pkg, tmat_ctrl and tmat_dp
//
// Each input beat carries one signed angle in hundredths of a degree. The
// table is scanned from entry 0 up and the first stored angle whose absolute
// difference is strictly below match_threshold is reported (status 0); with
// no match and room left the angle is appended (status 1); otherwise the
// table is full (status 2); a count above the limit in force gives status 3
// and changes nothing. The longest path for an item runs from its accept
// through a setup step, a read of each stored entry through the single read
// port of the table ram, a decision step, an append step and the result
// load, up to the next accept. A match ends the scan early, a full table
// skips the append, an append to an empty table skips the scan and the
// decision, and a count over the limit goes straight to the result load.
// The result load waits while the output register still holds an
// unaccepted beat; once loaded, the next input is taken while that result
// waits. Write the config port only while the block is idle.
module tolerance_match_or_append_table_core
  import tmat_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // config write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [THR_W-1:0]     cfg_data,
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [ANGLE_W-1:0]   in_tdata,   // [15:0] angle
  // result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,  // [4:0] match_index, [10:5] entry_total, zero above
  output logic [1:0]           out_tuser   // [1:0] status
);

  tmat_cmd_t              cmd;
  tmat_stat_t             stat;
  logic [IDX_OUT_W-1:0]   match_index;
  status_t                status;
  logic [TOTAL_OUT_W-1:0] entry_total;

  assign cfg_ready = 1'b1;

  tmat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tmat_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_angle        (in_tdata),
    .cmd             (cmd),
    .stat            (stat),
    .out_tready      (out_tready),
    .out_tvalid      (out_tvalid),
    .out_match_index (match_index),
    .out_status      (status),
    .out_entry_total (entry_total)
  );

  assign out_tdata = {5'd0, entry_total, match_index};
  assign out_tuser = status;

endmodule

// ===== tb/sv/tolerance_match_or_append_table_core_tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for tolerance_match_or_append_table_core: angle beats are
// scored against an in-bench model of the angle table; depends on tmat_pkg
module tolerance_match_or_append_table_core_tb;
  import tmat_pkg::*;

  localparam int RANDOM_ANGLES = 1900;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [IDX_OUT_W-1:0]   idx;
    status_t                status;
    logic [TOTAL_OUT_W-1:0] total;
  } table_result_t;

  typedef enum {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_PERIODIC} ready_mode_t;

  // angle table model and queue of results still owed by the block
  class angle_table_model;
    logic signed [ANGLE_W-1:0] store[TABLE_DEPTH_DEF];
    int unsigned               count;
    logic [MAX_ENT_W-1:0]      max_ent;
    logic [THR_W-1:0]          thr;
    table_result_t             pending[$];
    int                        fail_count;

    function new();
      count = 0;
      max_ent = MAX_ENT_RST;
      thr = THR_RST;
      fail_count = 0;
    endfunction

    function void set_reg(logic idx, logic [THR_W-1:0] value);
      if (idx == CFG_MAX_ENTRIES) max_ent = value[MAX_ENT_W-1:0];
      else thr = value;
    endfunction

    function void note_angle(logic signed [ANGLE_W-1:0] a);
      table_result_t r;
      int unsigned   limit;
      int            diff;
      bit            hit;
      limit = (max_ent < TABLE_DEPTH_DEF) ? max_ent : TABLE_DEPTH_DEF;
      r.idx = '0;
      r.status = ST_FULL;
      hit = 0;
      if (count > limit) begin
        r.status = ST_OVER;
      end else begin
        for (int i = 0; i < count && !hit; i++) begin
          diff = int'(store[i]) - int'(a);
          if (diff < 0) diff = -diff;
          if (diff < int'(thr)) begin
            hit = 1;
            r.idx = 5'(i);
            r.status = ST_MATCH;
          end
        end
        // empty table always takes the first angle, whatever the limit
        if (!hit && (count == 0 || count < limit)) begin
          store[count] = a;
          r.idx = 5'(count);
          r.status = ST_APPEND;
          count++;
        end
      end
      r.total = 6'(count);
      pending.push_back(r);
    endfunction

    function void check_result(logic [15:0] tdata, logic [1:0] tuser);
      table_result_t want;
      if (pending.size() == 0) begin
        $error("result beat with no angle pending: tdata %h tuser %h", tdata, tuser);
        fail_count++;
        return;
      end
      want = pending.pop_front();
      if (tdata[4:0] !== want.idx) begin
        $error("match_index: expected %0d, got %0d", want.idx, tdata[4:0]);
        fail_count++;
      end
      if (tdata[10:5] !== want.total) begin
        $error("entry_total: expected %0d, got %0d", want.total, tdata[10:5]);
        fail_count++;
      end
      if (tuser !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, tuser);
        fail_count++;
      end
      if (tdata[15:11] !== 5'd0) begin
        $error("tdata pad: expected 0, got %0h", tdata[15:11]);
        fail_count++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_index;
  logic [THR_W-1:0]   cfg_data;
  logic               in_tvalid;
  logic               in_tready;
  logic [ANGLE_W-1:0] in_tdata;   // [15:0] angle
  logic               out_tvalid;
  logic               out_tready;
  logic [15:0]        out_tdata;  // [4:0] match_index, [10:5] entry_total, zero above
  logic [1:0]         out_tuser;  // [1:0] status

  angle_table_model angle_table = new();
  int          burst_left = 0;
  int          cycles = 0;
  ready_mode_t ready_mode = RDY_ALWAYS;
  int          mode_left = 0;

  tolerance_match_or_append_table_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // called at a falling edge, returns at a falling edge
  task automatic cfg_write(input logic idx, input logic [THR_W-1:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    angle_table.set_reg(idx, value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // upper data bits are junk on a max_entries write, only [5:0] counts
  task automatic set_max_entries(input int unsigned m);
    logic [31:0] junk;
    junk = $urandom;
    cfg_write(CFG_MAX_ENTRIES, {junk[8:0], 6'(m)});
  endtask

  task automatic send_angle(input logic signed [ANGLE_W-1:0] a);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid = 1'b1;
    in_tdata = a;
    do @(posedge clk); while (!in_tready);
    angle_table.note_angle(a);
    burst_left--;
    @(negedge clk);
  endtask

  // drain before any register write
  task automatic end_phase();
    in_tvalid = 1'b0;
    while (angle_table.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic signed [ANGLE_W-1:0] pick_angle();
    int sel;
    int base;
    int off;
    int v;
    logic [31:0] r;
    sel = $urandom_range(0, 9);
    if (sel < 5 && angle_table.count > 0) begin
      // land near a stored angle, often right on the tolerance edge
      base = int'(angle_table.store[$urandom_range(0, angle_table.count - 1)]);
      case ($urandom_range(0, 2))
        0: off = int'(angle_table.thr);
        1: off = int'(angle_table.thr) - 1;
        default: off = $urandom_range(0, int'(angle_table.thr) + 2);
      endcase
      v = $urandom_range(0, 1) ? base + off : base - off;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return 16'(v);
    end
    if (sel < 7) begin
      r = $urandom;
      return r[15:0];
    end
    return 16'($urandom_range(0, 36000) - 18000);
  endfunction

  task automatic random_settings();
    int unsigned c;
    int unsigned m;
    int unsigned t;
    c = angle_table.count;
    case ($urandom_range(0, 8))
      0: m = 0;
      1: m = 1;
      2: m = c;
      3: m = c + 1;
      4: m = (c > 0) ? c - 1 : 0;
      5: m = 32;
      6: m = 33;
      7: m = 63;
      default: m = $urandom_range(0, 63);
    endcase
    case ($urandom_range(0, 6))
      0: t = 0;
      1: t = 1;
      2: t = 35;
      3: t = $urandom_range(0, 400);
      4: t = 18000;
      5: t = 32767;
      default: t = $urandom_range(0, 32767);
    endcase
    if ($urandom_range(0, 1)) begin
      set_max_entries(m);
      cfg_write(CFG_MATCH_THR, 15'(t));
    end else begin
      cfg_write(CFG_MATCH_THR, 15'(t));
      set_max_entries(m);
    end
  endtask

  // receiver stall pattern, switches style every so often
  always @(negedge clk) begin
    if (mode_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(20, 300);
    end
    mode_left--;
    case (ready_mode)
      RDY_ALWAYS:   out_tready = 1'b1;
      RDY_COIN:     out_tready = 1'($urandom_range(0, 1));
      RDY_SPARSE:   out_tready = ($urandom_range(0, 4) == 0);
      default:      out_tready = ((mode_left % 16) < 12);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      angle_table.check_result(out_tdata, out_tuser);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tolerance_match_or_append_table_core: mismatch");
      $finish;
    end
  end

  initial begin
    int sent;
    int n;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MAX_ENTRIES;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // zero limit: empty table still takes one, then count is over the limit
    set_max_entries(0);
    cfg_write(CFG_MATCH_THR, THR_RST);
    send_angle(-16'sd32768);
    send_angle(16'sd32767);
    end_phase();

    // limit of one: just inside tolerance matches, just outside is full
    set_max_entries(1);
    send_angle(-16'sd32734);
    send_angle(-16'sd32733);
    end_phase();

    // zero tolerance never matches, even an identical angle
    set_max_entries(63);
    cfg_write(CFG_MATCH_THR, 15'd0);
    send_angle(-16'sd32768);
    send_angle(16'sd0);
    end_phase();

    // widest tolerance against the widest differences
    cfg_write(CFG_MATCH_THR, 15'h7fff);
    send_angle(16'sd32767);
    send_angle(16'sd1);
    end_phase();

    cfg_write(CFG_MATCH_THR, THR_RST);
    send_angle(16'sd100);
    send_angle(-16'sd100);
    send_angle(16'sd18000);
    send_angle(-16'sd18000);
    send_angle(16'sd17999);
    send_angle(16'sh5555);
    send_angle(16'shaaaa);
    send_angle(16'sd35);
    send_angle(16'sd134);
    send_angle(16'sd66);
    end_phase();

    // limit at the count gives full, below it gives over
    set_max_entries(angle_table.count);
    send_angle(16'sd12345);
    end_phase();
    set_max_entries(3);
    send_angle(16'sd0);
    end_phase();

    set_max_entries(MAX_ENT_RST);
    sent = 0;
    while (sent < RANDOM_ANGLES) begin
      random_settings();
      n = $urandom_range(80, 220);
      repeat (n) send_angle(pick_angle());
      sent += n;
      end_phase();
    end

    repeat (50) @(posedge clk);
    if (angle_table.fail_count == 0 && angle_table.pending.size() == 0) begin
      $display("tolerance_match_or_append_table_core: match");
    end else begin
      $display("tolerance_match_or_append_table_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/tmat_pkg.sv
src/tmat_ram.sv
src/tmat_ctrl.sv
src/tmat_dp.sv
src/tolerance_match_or_append_table_core.sv
tb/sv/tolerance_match_or_append_table_core_tb.sv
